// File: rtl/text_console_writer_macros.svh
// Assertion macros for the text console writer.
// Used by the top level only; expects signals clk and arst_n in scope.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/tcw_pkg.sv
// Shared types, codes and constants of the text console writer.
// No dependencies; imported by every module of the block.
package tcw_pkg;

	localparam int DEF_COLS = 80;
	localparam int DEF_ROWS = 25;

	localparam int FUNC_W = 2;
	localparam int CH_W   = 8;
	localparam int ATTR_W = 8;
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int POS_W  = 12;
	localparam int CELL_W = CH_W + ATTR_W;

	localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

	localparam logic [CH_W-1:0] CH_NEWLINE   = 8'h0A;
	localparam logic [CH_W-1:0] CH_TAB       = 8'h09;
	localparam logic [CH_W-1:0] CH_BACKSPACE = 8'h08;
	localparam logic [CH_W-1:0] CH_BLANK     = 8'h20;
	localparam logic [CH_W-1:0] CH_ERROR     = 8'h45;

	localparam logic [ATTR_W-1:0] ATTR_DEFAULT = 8'h0F;
	localparam int TAB_STEP = 4;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [CH_W-1:0]   ch;
		logic [ATTR_W-1:0] attrib;
		logic              use_cursor;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
	} item_t;

	typedef struct packed {
		logic [POS_W-1:0]  position;
		logic              range_error;
		logic [CH_W-1:0]   read_char;
		logic [ATTR_W-1:0] read_attr;
	} result_t;

endpackage

// File: rtl/tcw_cell_mem.sv
// Character/attribute cell store: one write port, one registered read port.
// Depends on tcw_pkg for the cell width.
module tcw_cell_mem import tcw_pkg::*; #(
	parameter int SCREEN_COLS = DEF_COLS,
	parameter int SCREEN_ROWS = DEF_ROWS,
	localparam int CELLS = SCREEN_COLS * SCREEN_ROWS,
	localparam int AW = $clog2(CELLS)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [CELL_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [CELL_W-1:0] rdata
);

	logic [CELL_W-1:0] cells [CELLS];

	always_ff @(posedge clk) begin
		if (we) begin
			cells[waddr] <= wdata;
		end
		if (re) begin
			rdata <= cells[raddr];
		end
	end

endmodule

// File: rtl/tcw_ctrl.sv
// Sequencer of the text console writer: decodes a request, updates the cursor,
// drives the cell store and runs the scroll, clear and power-up sweeps.
// Depends on tcw_pkg.
module tcw_ctrl import tcw_pkg::*; #(
	parameter int SCREEN_COLS = DEF_COLS,
	parameter int SCREEN_ROWS = DEF_ROWS,
	localparam int CELLS = SCREEN_COLS * SCREEN_ROWS,
	localparam int AW = $clog2(CELLS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  item_t             item,
	output logic              item_ready,
	output logic              res_valid,
	output result_t           res,
	input  logic              res_free,
	output logic              mem_we,
	output logic [AW-1:0]     mem_waddr,
	output logic [CELL_W-1:0] mem_wdata,
	output logic              mem_re,
	output logic [AW-1:0]     mem_raddr,
	input  logic [CELL_W-1:0] mem_rdata
);

	localparam int CW = $clog2(SCREEN_COLS);
	localparam int RW = $clog2(SCREEN_ROWS + 1);
	localparam int COPY_END = CELLS - SCREEN_COLS;

	localparam logic [2:0] ST_INIT  = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_EXEC  = 3'd2;
	localparam logic [2:0] ST_READ  = 3'd3;
	localparam logic [2:0] ST_SWEEP = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]        state_q;
	item_t             item_q;
	logic [RW-1:0]     cur_row_q;
	logic [CW-1:0]     cur_col_q;
	logic [AW-1:0]     cnt_q;
	logic              copy_q;
	logic [CELL_W-1:0] fill_q;
	logic              wr_s1;
	logic [AW-1:0]     waddr_s1;
	logic              copy_s1;
	logic              err_q;
	logic [POS_W-1:0]  errpos_q;
	logic [CH_W-1:0]   rchar_q;
	logic [ATTR_W-1:0] rattr_q;

	logic [POS_W-1:0]  lin;
	logic              off_screen;
	logic [RW-1:0]     base_row;
	logic [CW-1:0]     base_col;
	logic [AW-1:0]     base_idx;
	logic [AW-1:0]     cur_idx;
	logic [ATTR_W-1:0] attr_eff;
	logic [CW:0]       col_sum;
	logic              col_wrap;
	logic [RW-1:0]     next_row;
	logic [CW-1:0]     next_col;
	logic              put_write;
	logic              copy_rd;
	logic              sweep_last;

	assign lin = POS_W'(POS_W'(item_q.row) * POS_W'(SCREEN_COLS) + POS_W'(item_q.col));
	assign off_screen = (int'(item_q.col) >= SCREEN_COLS) || (int'(item_q.row) >= SCREEN_ROWS);

	assign base_row = item_q.use_cursor ? cur_row_q : RW'(item_q.row);
	assign base_col = item_q.use_cursor ? cur_col_q : CW'(item_q.col);
	assign base_idx = AW'(AW'(base_row) * AW'(SCREEN_COLS) + AW'(base_col));
	assign cur_idx  = AW'(AW'(cur_row_q) * AW'(SCREEN_COLS) + AW'(cur_col_q));

	assign attr_eff = (item_q.attrib == '0) ? ATTR_DEFAULT : item_q.attrib;

	// A tab spills at most a few cells into the next row, never two rows.
	assign col_sum  = (CW + 1)'(base_col) + ((item_q.ch == CH_TAB) ? (CW + 1)'(TAB_STEP)
		: (CW + 1)'(1));
	assign col_wrap = col_sum >= (CW + 1)'(SCREEN_COLS);

	always_comb begin
		next_row  = base_row;
		next_col  = base_col;
		put_write = 1'b1;
		case (item_q.ch)
			CH_NEWLINE: begin
				next_row  = base_row + RW'(1);
				next_col  = '0;
				put_write = 1'b0;
			end
			CH_BACKSPACE: begin
			end
			default: begin
				if (item_q.ch == CH_TAB) begin
					put_write = 1'b0;
				end
				if (col_wrap) begin
					next_row = base_row + RW'(1);
					next_col = CW'(col_sum - (CW + 1)'(SCREEN_COLS));
				end else begin
					next_col = CW'(col_sum);
				end
			end
		endcase
	end

	assign copy_rd    = copy_q && (int'(cnt_q) < COPY_END);
	assign sweep_last = (cnt_q == AW'(CELLS - 1));

	// Store port: each sweep write follows its read in the next cycle, through the _s1 stage.
	always_comb begin
		mem_we    = wr_s1;
		mem_waddr = waddr_s1;
		mem_wdata = copy_s1 ? mem_rdata : fill_q;
		mem_re    = 1'b0;
		mem_raddr = AW'(cnt_q + AW'(SCREEN_COLS));
		unique case (state_q)
			ST_INIT, ST_SWEEP: begin
				mem_re = copy_rd;
			end
			ST_EXEC: begin
				unique case (item_q.func)
					FUNC_PUT: begin
						if (!item_q.use_cursor && off_screen) begin
							mem_we    = 1'b1;
							mem_waddr = AW'(CELLS - 1);
							mem_wdata = {ATTR_DEFAULT, CH_ERROR};
						end else begin
							mem_we    = put_write;
							mem_waddr = base_idx;
							mem_wdata = {attr_eff,
								(item_q.ch == CH_BACKSPACE) ? CH_BLANK : item_q.ch};
						end
					end
					FUNC_READ: begin
						mem_re    = !off_screen;
						mem_raddr = AW'(lin);
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	assign item_ready          = (state_q == ST_IDLE);
	assign res_valid           = (state_q == ST_DONE);
	assign res.position        = err_q ? errpos_q : POS_W'(cur_idx);
	assign res.range_error     = err_q;
	assign res.read_char       = rchar_q;
	assign res.read_attr       = rattr_q;

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_INIT;
			cur_row_q <= '0;
			cur_col_q <= '0;
			cnt_q     <= '0;
			copy_q    <= 1'b0;
			fill_q    <= '0;
			wr_s1     <= 1'b0;
			waddr_s1  <= '0;
			copy_s1   <= 1'b0;
			err_q     <= 1'b0;
			errpos_q  <= '0;
			rchar_q   <= '0;
			rattr_q   <= '0;
		end else begin
			wr_s1 <= 1'b0;
			unique case (state_q)
				ST_INIT, ST_SWEEP: begin
					wr_s1    <= 1'b1;
					waddr_s1 <= cnt_q;
					copy_s1  <= copy_rd;
					cnt_q    <= cnt_q + AW'(1);
					if (sweep_last) begin
						state_q <= (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
					end
				end
				ST_IDLE: begin
					if (item_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					err_q   <= 1'b0;
					rchar_q <= '0;
					rattr_q <= '0;
					cnt_q   <= '0;
					state_q <= ST_DONE;
					unique case (item_q.func)
						FUNC_PUT: begin
							if (!item_q.use_cursor && off_screen) begin
								err_q    <= 1'b1;
								errpos_q <= lin;
							end else if (int'(next_row) == SCREEN_ROWS) begin
								// Ran off the end: scroll up and zero the last row.
								cur_row_q <= RW'(SCREEN_ROWS - 1);
								cur_col_q <= next_col;
								fill_q    <= '0;
								copy_q    <= 1'b1;
								state_q   <= ST_SWEEP;
							end else begin
								cur_row_q <= next_row;
								cur_col_q <= next_col;
							end
						end
						FUNC_READ: begin
							if (off_screen) begin
								err_q    <= 1'b1;
								errpos_q <= lin;
							end else begin
								state_q <= ST_READ;
							end
						end
						FUNC_CLEAR: begin
							cur_row_q <= '0;
							cur_col_q <= '0;
							fill_q    <= {ATTR_DEFAULT, CH_BLANK};
							copy_q    <= 1'b0;
							state_q   <= ST_SWEEP;
						end
						default: begin
						end
					endcase
				end
				ST_READ: begin
					rchar_q <= mem_rdata[CH_W-1:0];
					rattr_q <= mem_rdata[CELL_W-1:CH_W];
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/text_console_writer.sv
// Channel  | direction | tvalid/tready  | tdata                          | tuser
// request  | in        | s_axis_*       | ch, attrib, col, row           | func, use_cursor
// result   | out       | m_axis_*       | position, read_char, read_attr | range_error
//
// A put, an off-screen read or an unused code passes through the EXEC and DONE states;
// leaving DONE, once the result register is free, loads it and frees the input together.
// An in-range read adds the READ state. A scroll or a clear adds a sweep over all
// SCREEN_COLS*SCREEN_ROWS cells, one cell per cycle. After reset a like sweep zeroes the
// store before the first request is taken. A result waiting on m_axis_tready does not
// block the next request; only its completion waits for the result register.
`include "text_console_writer_macros.svh"

module text_console_writer import tcw_pkg::*; #(
	parameter int SCREEN_COLS = DEF_COLS,
	parameter int SCREEN_ROWS = DEF_ROWS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // ch[7:0], attrib[15:8], col[22:16], row[27:23]
	input  logic [2:0]  s_axis_tuser,  // func[1:0], use_cursor[2]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // position[11:0], read_char[19:12], read_attr[27:20]
	output logic        m_axis_tuser   // range_error
);

	localparam int CELLS = SCREEN_COLS * SCREEN_ROWS;
	localparam int AW = $clog2(CELLS);

	item_t             item;
	result_t           ctrl_res;
	result_t           res_q;
	logic              ctrl_res_valid;
	logic              res_free;
	logic              m_valid_q;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [CELL_W-1:0] mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [CELL_W-1:0] mem_rdata;

	assign item.func       = s_axis_tuser[1:0];
	assign item.use_cursor = s_axis_tuser[2];
	assign item.ch         = s_axis_tdata[7:0];
	assign item.attrib     = s_axis_tdata[15:8];
	assign item.col        = s_axis_tdata[22:16];
	assign item.row        = s_axis_tdata[27:23];

	tcw_ctrl #(
		.SCREEN_COLS(SCREEN_COLS),
		.SCREEN_ROWS(SCREEN_ROWS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (s_axis_tvalid),
		.item       (item),
		.item_ready (s_axis_tready),
		.res_valid  (ctrl_res_valid),
		.res        (ctrl_res),
		.res_free   (res_free),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	tcw_cell_mem #(
		.SCREEN_COLS(SCREEN_COLS),
		.SCREEN_ROWS(SCREEN_ROWS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Result register: loads when empty or when its current result is taken.
	assign res_free = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (ctrl_res_valid && res_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_res_valid && res_free) begin
			res_q <= ctrl_res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {4'b0, res_q.read_attr, res_q.read_char, res_q.position};
	assign m_axis_tuser  = res_q.range_error;

	`TCW_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request accepted while busy")
	`TCW_ASSERT_SAME(a_no_result_idle, ctrl_res_valid, !s_axis_tready, "result pending while idle")
	`TCW_ASSERT_NEXT(a_result_waits, ctrl_res_valid && !res_free, ctrl_res_valid && $stable(ctrl_res), "result dropped while output full")
	`TCW_ASSERT_SAME(a_store_one_access, mem_we && s_axis_tready, !ctrl_res_valid, "store write while idle and done")

endmodule
